@@ sv/lcps_pkg.sv @@
`timescale 1ns / 1ps
package lcps_pkg;

	localparam int FRAME_PIXELS = 128;
	localparam int PIXEL_BITS   = 12;

	localparam int PIX_W      = 12;
	localparam int POS_W      = 7;
	localparam int DUTY_W     = 7;
	localparam int GAIN_P_W   = 10;
	localparam int GAIN_D_W   = 12;
	localparam int ERR_W      = 8;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int ERR_WIDE_W = 12;
	localparam int U_W        = 23;
	localparam int FL_W       = U_W - 8;
	localparam int SERVO_W    = FL_W + 2;
	localparam int Q_W        = 4;
	localparam int MOTOR_W    = 14;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);
	localparam logic [POS_W-1:0] POS_RESET = POS_W'(64);

	localparam logic [DUTY_W-1:0]   CENTER_RESET  = DUTY_W'(14);
	localparam logic [DUTY_W-1:0]   LOW_RESET     = DUTY_W'(7);
	localparam logic [DUTY_W-1:0]   HIGH_RESET    = DUTY_W'(24);
	localparam logic [GAIN_P_W-1:0] GAIN_P_RESET  = GAIN_P_W'(64);
	localparam logic [GAIN_D_W-1:0] GAIN_D_RESET  = GAIN_D_W'(640);
	localparam logic [DUTY_W-1:0]   SLOW_RESET    = DUTY_W'(19);
	localparam logic [DUTY_W-1:0]   FAST_RESET    = DUTY_W'(19);
	localparam logic [DUTY_W-1:0]   DUTY_MAX      = DUTY_W'(100);

	typedef enum logic [2:0] {
		REG_CENTER = 3'd0,
		REG_LOW    = 3'd1,
		REG_HIGH   = 3'd2,
		REG_GAIN_P = 3'd3,
		REG_GAIN_D = 3'd4,
		REG_SLOW   = 3'd5,
		REG_FAST   = 3'd6
	} reg_idx_t;

endpackage

@@ sv/line_camera_pd_steering.sv @@
`timescale 1ns / 1ps
// channel   | handshake                    | payload
// ----------+------------------------------+-----------------------------------------
// item      | item_valid / item_stall      | mode, pixel_value, frame_end
// result    | result_valid / result_stall  | servo_duty, motor_duty, line_position
// config    | psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// one item accepted per cycle while item_stall is low; pixel items update the argmax
// at once and give no result; a tick runs through four registered stages (error, pd sum,
// clamp and quotient, motor) and its result shows from the output register
// reset clears config to defaults, argmax state, held position 64 and all stage valids
// result_stall holds the output; stages fill bubbles, item_stall rises only when all are full
module line_camera_pd_steering
	import lcps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 mode,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 frame_end,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [DUTY_W-1:0]    servo_duty,
	output logic [DUTY_W-1:0]    motor_duty,
	output logic [POS_W-1:0]     line_position,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	localparam logic signed [ERR_WIDE_W-1:0] ERR_HI = ERR_WIDE_W'(127);
	localparam logic signed [ERR_WIDE_W-1:0] ERR_LO = ERR_WIDE_W'(-128);

	logic [DUTY_W-1:0]   center_q, low_q, high_q, slow_q, fast_q;
	logic [GAIN_P_W-1:0] gain_p_q;
	logic [GAIN_D_W-1:0] gain_d_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;

	logic [PIX_W-1:0]        running_max_q;
	logic [POS_W-1:0]        running_index_q, pixel_count_q, held_q;
	logic signed [ERR_W-1:0] prev_err_q;

	logic v_s1, v_s2, v_s3, out_v_q;
	logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
	logic acc, pix_acc, tick_acc;

	logic [PIX_W-1:0]             pix;
	logic                         pix_gt;
	logic signed [ERR_WIDE_W-1:0] err_wide;
	logic signed [ERR_W-1:0]      err;
	logic signed [DIFF_W-1:0]     diff;

	logic signed [ERR_W-1:0]  err_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic [POS_W-1:0]         pos_s1;

	logic signed [GAIN_P_W+ERR_W:0]    prod_p;
	logic signed [GAIN_D_W+DIFF_W:0]   prod_d;
	logic signed [U_W-1:0]             u;
	logic signed [U_W-1:0]             u_s2;
	logic [POS_W-1:0]                  pos_s2;

	logic signed [FL_W-1:0]    fl;
	logic signed [SERVO_W-1:0] servo_raw, lo_ext, hi_ext;
	logic [DUTY_W-1:0]         servo, delta;
	logic                      below;
	logic [14:0]               m10;
	logic [Q_W-1:0]            q;
	logic [DUTY_W-1:0]         servo_s3;
	logic [Q_W-1:0]            q_s3;
	logic [POS_W-1:0]          pos_s3;

	logic signed [DUTY_W:0]    span;
	logic signed [DUTY_W+Q_W+1:0] mprod;
	logic signed [MOTOR_W-1:0] motor_w;
	logic [DUTY_W-1:0]         motor;

	logic [DUTY_W-1:0] servo_q, motor_q;
	logic [POS_W-1:0]  pos_q;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RESET;
			low_q    <= LOW_RESET;
			high_q   <= HIGH_RESET;
			gain_p_q <= GAIN_P_RESET;
			gain_d_q <= GAIN_D_RESET;
			slow_q   <= SLOW_RESET;
			fast_q   <= FAST_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_CENTER: center_q <= pwdata[DUTY_W-1:0];
				REG_LOW:    low_q    <= pwdata[DUTY_W-1:0];
				REG_HIGH:   high_q   <= pwdata[DUTY_W-1:0];
				REG_GAIN_P: gain_p_q <= pwdata[GAIN_P_W-1:0];
				REG_GAIN_D: gain_d_q <= pwdata[GAIN_D_W-1:0];
				REG_SLOW:   slow_q   <= pwdata[DUTY_W-1:0];
				REG_FAST:   fast_q   <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CENTER: prdata = DATA_W'(center_q);
			REG_LOW:    prdata = DATA_W'(low_q);
			REG_HIGH:   prdata = DATA_W'(high_q);
			REG_GAIN_P: prdata = DATA_W'(gain_p_q);
			REG_GAIN_D: prdata = DATA_W'(gain_d_q);
			REG_SLOW:   prdata = DATA_W'(slow_q);
			REG_FAST:   prdata = DATA_W'(fast_q);
			default:    prdata = '0;
		endcase
	end

	// flow control
	assign out_rdy    = !out_v_q || !result_stall;
	assign s3_rdy     = !v_s3 || out_rdy;
	assign s2_rdy     = !v_s2 || s3_rdy;
	assign s1_rdy     = !v_s1 || s2_rdy;
	assign item_stall = !s1_rdy;
	assign acc        = item_valid && !item_stall;
	assign pix_acc    = acc && !mode;
	assign tick_acc   = acc && mode;

	// argmax and error at acceptance
	assign pix      = pixel_value & PIX_MASK;
	assign pix_gt   = pix > running_max_q;
	assign err_wide = $signed(ERR_WIDE_W'(FRAME_PIXELS / 2) - ERR_WIDE_W'(held_q));

	always_comb begin
		if (err_wide > ERR_HI) begin
			err = ERR_HI[ERR_W-1:0];
		end else if (err_wide < ERR_LO) begin
			err = ERR_LO[ERR_W-1:0];
		end else begin
			err = err_wide[ERR_W-1:0];
		end
	end

	assign diff = DIFF_W'(err) - DIFF_W'(prev_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_max_q   <= '0;
			running_index_q <= '0;
			pixel_count_q   <= '0;
			held_q          <= POS_RESET;
			prev_err_q      <= '0;
		end else begin
			if (pix_acc) begin
				if (frame_end) begin
					held_q          <= pix_gt ? pixel_count_q : running_index_q;
					running_max_q   <= '0;
					running_index_q <= '0;
					pixel_count_q   <= '0;
				end else begin
					if (pix_gt) begin
						running_max_q   <= pix;
						running_index_q <= pixel_count_q;
					end
					pixel_count_q <= pixel_count_q + POS_W'(1);
				end
			end
			if (tick_acc) begin
				prev_err_q <= err;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_rdy) begin
				v_s1 <= tick_acc;
			end
			if (s2_rdy) begin
				v_s2 <= v_s1;
			end
			if (s3_rdy) begin
				v_s3 <= v_s2;
			end
			if (out_rdy) begin
				out_v_q <= v_s3;
			end
		end
	end

	// stage 1: error and diff
	always_ff @(posedge clk) begin
		if (s1_rdy) begin
			err_s1  <= err;
			diff_s1 <= diff;
			pos_s1  <= held_q;
		end
	end

	// stage 2: pd sum
	assign prod_p = (GAIN_P_W+ERR_W+1)'($signed({1'b0, gain_p_q}))
		* (GAIN_P_W+ERR_W+1)'(err_s1);
	assign prod_d = (GAIN_D_W+DIFF_W+1)'($signed({1'b0, gain_d_q}))
		* (GAIN_D_W+DIFF_W+1)'(diff_s1);
	assign u      = U_W'(prod_p) + U_W'(prod_d);

	always_ff @(posedge clk) begin
		if (s2_rdy) begin
			u_s2   <= u;
			pos_s2 <= pos_s1;
		end
	end

	// stage 3: floor divide, clamp, speed quotient
	assign fl        = u_s2[U_W-1:8];
	assign servo_raw = $signed(SERVO_W'(center_q)) - SERVO_W'(fl);
	assign lo_ext    = $signed(SERVO_W'(low_q));
	assign hi_ext    = $signed(SERVO_W'(high_q));

	always_comb begin
		if (servo_raw < lo_ext) begin
			servo = low_q;
		end else if (servo_raw > hi_ext) begin
			servo = high_q;
		end else begin
			servo = servo_raw[DUTY_W-1:0];
		end
	end

	assign below = servo < center_q;
	assign delta = below ? (center_q - servo) : (servo - center_q);
	// divide by ten as multiply by 205/2048, exact below 1029
	assign m10   = 15'(delta) * 15'(205);
	assign q     = below ? delta[DUTY_W-1:3] : m10[14:11];

	always_ff @(posedge clk) begin
		if (s3_rdy) begin
			servo_s3 <= servo;
			q_s3     <= q;
			pos_s3   <= pos_s2;
		end
	end

	// output stage: motor duty
	assign span    = $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
	assign mprod   = (DUTY_W+Q_W+2)'(span) * (DUTY_W+Q_W+2)'($signed({1'b0, q_s3}));
	assign motor_w = $signed(MOTOR_W'(fast_q)) - MOTOR_W'(mprod);

	always_comb begin
		if (motor_w < 0) begin
			motor = '0;
		end else if (motor_w > $signed(MOTOR_W'(DUTY_MAX))) begin
			motor = DUTY_MAX;
		end else begin
			motor = motor_w[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			servo_q <= servo_s3;
			motor_q <= motor;
			pos_q   <= pos_s3;
		end
	end

	assign result_valid  = out_v_q;
	assign servo_duty    = servo_q;
	assign motor_duty    = motor_q;
	assign line_position = pos_q;

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && frame_end |=> pixel_count_q == '0 && running_max_q == '0)
		else $error("argmax state not cleared after frame end");

	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> v_s1)
		else $error("accepted tick lost before stage 1");

	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> motor_duty <= DUTY_MAX)
		else $error("motor duty above 100");

	a_servo_limits: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (servo_duty == low_q || servo_duty == high_q
			|| (servo_duty > low_q && servo_duty < high_q)))
		else $error("servo duty outside limits");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import lcps_pkg::*;

	localparam logic MODE_PIXEL  = 1'b0;
	localparam logic MODE_TICK   = 1'b1;
	localparam int   PHASES      = 6;
	localparam int   PHASE_ITEMS = 140;
	localparam int   HOLD_CYCLES = 80;
	localparam int   SETTLE      = 8;
	localparam int   STUCK_LIMIT = 4000;

	typedef struct packed {
		logic [DUTY_W-1:0] servo;
		logic [DUTY_W-1:0] motor;
		logic [POS_W-1:0]  pos;
	} steer_out_t;

	class steer_scoreboard;
		logic [DUTY_W-1:0]       center, low_lim, high_lim, slow, fast;
		logic [GAIN_P_W-1:0]     gain_p;
		logic [GAIN_D_W-1:0]     gain_d;
		logic [PIX_W-1:0]        run_max;
		logic [POS_W-1:0]        run_idx, pix_cnt, held_pos;
		logic signed [ERR_W-1:0] prev_err;
		steer_out_t              expected_duties[$];
		int                      mismatches;
		int                      checked;

		function new();
			center     = CENTER_RESET;
			low_lim    = LOW_RESET;
			high_lim   = HIGH_RESET;
			gain_p     = GAIN_P_RESET;
			gain_d     = GAIN_D_RESET;
			slow       = SLOW_RESET;
			fast       = FAST_RESET;
			run_max    = '0;
			run_idx    = '0;
			pix_cnt    = '0;
			held_pos   = POS_RESET;
			prev_err   = '0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void set_reg(reg_idx_t r, logic [DATA_W-1:0] v);
			case (r)
				REG_CENTER: center   = v[DUTY_W-1:0];
				REG_LOW:    low_lim  = v[DUTY_W-1:0];
				REG_HIGH:   high_lim = v[DUTY_W-1:0];
				REG_GAIN_P: gain_p   = v[GAIN_P_W-1:0];
				REG_GAIN_D: gain_d   = v[GAIN_D_W-1:0];
				REG_SLOW:   slow     = v[DUTY_W-1:0];
				REG_FAST:   fast     = v[DUTY_W-1:0];
				default: ;
			endcase
		endfunction

		function steer_out_t steer_law();
			steer_out_t o;
			int err, diff, u, servo, q, motor;
			err = FRAME_PIXELS / 2 - int'(held_pos);
			if (err > 127)
				err = 127;
			if (err < -128)
				err = -128;
			diff = err - int'(prev_err);
			u = int'(gain_p) * err + int'(gain_d) * diff;
			servo = int'(center) - (u >>> 8);
			if (servo < int'(low_lim))
				servo = int'(low_lim);
			else if (servo > int'(high_lim))
				servo = int'(high_lim);
			if (servo < int'(center))
				q = (int'(center) - servo) / 8;
			else
				q = (servo - int'(center)) / 10;
			motor = int'(fast) - (int'(fast) - int'(slow)) * q;
			if (motor < 0)
				motor = 0;
			if (motor > 100)
				motor = 100;
			prev_err = ERR_W'(err);
			o.servo = DUTY_W'(servo);
			o.motor = DUTY_W'(motor);
			o.pos   = held_pos;
			return o;
		endfunction

		function void note_item(logic m, logic [PIX_W-1:0] pv, logic fe);
			logic [PIX_W-1:0] p;
			p = pv & PIX_MASK;
			if (m == MODE_TICK) begin
				expected_duties.push_back(steer_law());
			end else begin
				if (p > run_max) begin
					run_max = p;
					run_idx = pix_cnt;
				end
				pix_cnt = pix_cnt + 1'b1;
				if (fe) begin
					held_pos = run_idx;
					run_max  = '0;
					run_idx  = '0;
					pix_cnt  = '0;
				end
			end
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(steer_out_t got);
			steer_out_t want;
			if (expected_duties.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no tick pending (servo %0d motor %0d pos %0d)",
						$time, got.servo, got.motor, got.pos);
			end else begin
				want = expected_duties.pop_front();
				checked++;
				compare_field("servo_duty", want.servo, got.servo);
				compare_field("motor_duty", want.motor, got.motor);
				compare_field("line_position", want.pos, got.pos);
			end
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	logic                mode         = MODE_PIXEL;
	logic [PIX_W-1:0]    pixel_value  = '0;
	logic                frame_end    = 1'b0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [DUTY_W-1:0]   servo_duty;
	logic [DUTY_W-1:0]   motor_duty;
	logic [POS_W-1:0]    line_position;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	steer_scoreboard steering;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_left    = 0;
	int items_sent   = 0;
	int ticks_sent   = 0;
	int stuck_cycles = 0;

	line_camera_pd_steering dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else
			result_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			steering.check_result({servo_duty, motor_duty, line_position});
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) || psel)
			stuck_cycles = 0;
		else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("no handshake for %0d cycles, %0d ticks still pending",
				stuck_cycles, steering.expected_duties.size());
			$display("line_camera_pd_steering verification failed");
			$finish;
		end else
			stuck_cycles++;
	end

	task automatic send_item(input logic m, input logic [PIX_W-1:0] pv, input logic fe);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid  <= 1'b1;
		mode        <= m;
		pixel_value <= pv;
		frame_end   <= fe;
		do @(posedge clk); while (item_stall);
		steering.note_item(m, pv, fe);
		items_sent++;
		if (m == MODE_TICK)
			ticks_sent++;
	endtask

	task automatic send_tick();
		send_item(MODE_TICK, PIX_W'($urandom), 1'($urandom_range(1)));
	endtask

	task automatic send_frame(input int len);
		int               peak, style;
		logic [PIX_W-1:0] top, pv;
		peak  = $urandom_range(len - 1);
		top   = PIX_W'($urandom);
		style = $urandom_range(9);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 3)
				send_tick();
			if (style == 0)
				pv = '0;
			else if (style < 5)
				pv = PIX_W'($urandom);
			else if (i == peak)
				pv = top;
			else
				pv = PIX_W'($urandom_range(top));
			send_item(MODE_PIXEL, pv, i == len - 1);
		end
	endtask

	task automatic drain();
		@(negedge clk) item_valid <= 1'b0;
		while (steering.expected_duties.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [DATA_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({r, 2'b00});
		pwdata  <= v;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		steering.set_reg(r, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic program_phase(input int p);
		int unsigned vals[7];
		case (p)
			1: vals = '{50, 0, 100, 1023, 4095, 0, 100};
			2: vals = '{100, 100, 0, 0, 4095, 100, 0};
			3: vals = '{0, 0, 100, 1023, 0, 100, 0};
			default: begin
				vals = '{$urandom_range(100), $urandom_range(100), $urandom_range(100),
					$urandom_range(1023), $urandom_range(4095),
					$urandom_range(100), $urandom_range(100)};
			end
		endcase
		for (int i = 0; i < 7; i++)
			write_reg(reg_idx_t'(i), vals[i]);
	endtask

	initial begin
		int r, len, items0, ticks0;
		steering = new();
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				program_phase(phase);
			end
			@(posedge clk);
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
				default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
			endcase

			if (phase == 0) begin
				// reset position, ignored fields set on a tick
				send_item(MODE_TICK, '1, 1'b1);
				// all-zero frame gives position 0
				send_item(MODE_PIXEL, '0, 1'b0);
				send_item(MODE_PIXEL, '0, 1'b0);
				send_item(MODE_PIXEL, '0, 1'b1);
				send_item(MODE_TICK, '0, 1'b0);
				// tie on the maximum, first one wins
				send_item(MODE_PIXEL, 12'd5, 1'b0);
				send_item(MODE_PIXEL, '1, 1'b0);
				send_item(MODE_PIXEL, '1, 1'b0);
				send_item(MODE_PIXEL, 12'd7, 1'b1);
				send_tick();
				// tick in the middle of a frame
				send_item(MODE_PIXEL, 12'd200, 1'b0);
				send_tick();
				send_item(MODE_PIXEL, '1, 1'b1);
				send_tick();
				send_item(MODE_PIXEL, '1, 1'b1);
				send_tick();
				send_tick();
			end

			if (phase == 1 || phase == 4) begin
				hold_left = HOLD_CYCLES;
				repeat (24) send_tick();
			end

			items0 = items_sent;
			ticks0 = ticks_sent;
			while (items_sent - items0 < PHASE_ITEMS || ticks_sent - ticks0 < 10) begin
				r = $urandom_range(99);
				if (r < 85) begin
					r = $urandom_range(99);
					if (r < 70)
						len = $urandom_range(24, 1);
					else if (r < 95)
						len = $urandom_range(128, 25);
					else
						len = $urandom_range(170, 129);
					send_frame(len);
					repeat ($urandom_range(2, 1)) send_tick();
				end else begin
					repeat ($urandom_range(6, 1))
						send_item(1'($urandom_range(1)), PIX_W'($urandom),
							$urandom_range(7) == 0);
				end
			end
		end
		drain();

		$display("run: %0d items, %0d ticks, %0d results checked over %0d register settings",
			items_sent, ticks_sent, steering.checked, PHASES);
		$display("idle mixes: none, sender 66%%, receiver 66%%, both 6%%, with long output holds");
		if (steering.mismatches == 0 && steering.expected_duties.size() == 0) begin
			$display("line_camera_pd_steering verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", steering.mismatches,
				steering.expected_duties.size());
			$display("line_camera_pd_steering verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/lcps_pkg.sv
sv/line_camera_pd_steering.sv
verif/tb.sv
